/* hdl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define NBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define NBF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/nbf_pkg.sv */
// Package for the newline batch framer: widths, codes and request types.
// No dependencies; used by the interfaces and all framer modules.
`default_nettype none

package nbf_pkg;

  localparam int unsigned OFFSET_BITS = 48;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned LIMIT_BITS  = 32;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0]             NEWLINE_BYTE = 8'h0A;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX   = {OFFSET_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

  // Budget sum: payload up to the offset width plus eight bytes per line.
  localparam int unsigned BUDGET_W = OFFSET_BITS + 1;

  // Result queue.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINES_PER_BATCH = 2'd0,
    CFG_BYTE_LIMIT      = 2'd1,
    CFG_START_OFFSET    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BATCH    = 2'd0,
    KIND_SENTINEL = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
  } nbf_in_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] batch_offset;
    logic [COUNT_BITS-1:0]  line_count;
    logic                   partial;
    kind_e                  kind;
    logic                   last;
  } nbf_res_t;

  // Up to two results produced by one request, in order.
  typedef struct packed {
    logic [1:0] num;
    nbf_res_t   r0;
    nbf_res_t   r1;
  } nbf_push_t;

endpackage

`default_nettype wire

/* hdl/nbf_if.sv */
// Valid/ready stream interfaces for the framer input bytes and results.
// Depends on nbf_pkg for the payload types.
`default_nettype none

interface nbf_in_if import nbf_pkg::*; ();
  logic    valid;
  logic    ready;
  nbf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nbf_out_if import nbf_pkg::*; ();
  logic     valid;
  logic     ready;
  nbf_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/newline_batch_framer.sv */
// Newline batch framer: the results of a request are registered in the result queue and leave from its head.
// Throughput: one byte per cycle while the queue has room; the results of a byte leave one at a
// time, and input stalls when the four-entry result queue has fewer than two free slots.
// Reset: registers to their defaults, framing state cleared, queue empty; no clearing pass.
// Depends on nbf_pkg, nbf_if, nbf_core and nbf_out_fifo.
`default_nettype none

module newline_batch_framer import nbf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  nbf_in_if.sink                     in_ch_i,
  nbf_out_if.source                  out_ch_o
);

  nbf_push_t push;
  logic      room;
  logic      in_acc;

  // A request is taken whenever the queue can hold its results.
  assign in_ch_i.ready = room;
  assign in_acc        = in_ch_i.valid && room;

  nbf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_acc_i   (in_acc),
    .in_req_i   (in_ch_i.payload),
    .push_o     (push)
  );

  nbf_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_ch_o.valid),
    .ready_i (out_ch_o.ready),
    .data_o  (out_ch_o.payload)
  );

endmodule

`default_nettype wire

/* hdl/nbf_core.sv */
// Framing state and per-byte decision logic of the newline batch framer.
// Depends on nbf_pkg and assert_macros.svh; feeds up to two results to the queue.
`default_nettype none
`include "assert_macros.svh"

module nbf_core import nbf_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_acc_i,
  input  wire nbf_in_t                in_req_i,
  output nbf_push_t                   push_o
);

  logic [COUNT_BITS-1:0]  lpb_q;
  logic [LIMIT_BITS-1:0]  limit_q;
  logic [OFFSET_BITS-1:0] start_q;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] bb_q, bb_d;
  logic [OFFSET_BITS-1:0] lb_q, lb_d;
  logic [COUNT_BITS-1:0]  lines_q, lines_d;
  logic                   open_q, open_d;
  logic                   halted_q, halted_d;

  logic [OFFSET_BITS-1:0] next_pos;
  logic [COUNT_BITS-1:0]  end_cnt;
  logic [OFFSET_BITS-1:0] payload;
  logic [COUNT_BITS+3:0]  overhead;
  logic [BUDGET_W-1:0]    budget_sum;
  logic                   over_budget;
  logic                   start_wr;

  function automatic nbf_res_t mk_res(logic [OFFSET_BITS-1:0] off,
                                      logic [COUNT_BITS-1:0] cnt,
                                      logic part, kind_e kind);
    nbf_res_t r;
    r.batch_offset = off;
    r.line_count   = cnt;
    r.partial      = part;
    r.kind         = kind;
    r.last         = 1'b0;
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpb_q   <= COUNT_BITS'(1);
      limit_q <= '0;
      start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINES_PER_BATCH: lpb_q   <= cfg_data_i[COUNT_BITS-1:0];
        CFG_BYTE_LIMIT:      limit_q <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_START_OFFSET:    start_q <= cfg_data_i[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign start_wr = cfg_we_i && (cfg_idx_i == CFG_START_OFFSET);

  // Budget check: bytes of the batch so far including this newline,
  // plus eight bytes for each line it would then hold.
  assign next_pos    = pos_q + OFFSET_BITS'(1);
  assign end_cnt     = lines_q + COUNT_BITS'(open_q);
  assign payload     = next_pos - bb_q;
  assign overhead    = {1'b0, lines_q, 3'b000} + (COUNT_BITS+4)'(8);
  assign budget_sum  = {1'b0, payload} + BUDGET_W'(overhead);
  assign over_budget = (limit_q != '0) && (lines_q != '0) &&
                       (budget_sum > BUDGET_W'(limit_q));

  // Next framing state and the results of one request.
  always_comb begin
    logic [OFFSET_BITS-1:0] bb_t;
    logic [COUNT_BITS-1:0]  lines_t;
    nbf_res_t               res_t;

    pos_d    = pos_q;
    bb_d     = bb_q;
    lb_d     = lb_q;
    lines_d  = lines_q;
    open_d   = open_q;
    halted_d = halted_q;
    push_o   = '0;
    bb_t     = bb_q;
    lines_t  = lines_q;
    res_t    = '0;

    if (start_wr) begin
      pos_d    = cfg_data_i[OFFSET_BITS-1:0];
      bb_d     = cfg_data_i[OFFSET_BITS-1:0];
      lb_d     = cfg_data_i[OFFSET_BITS-1:0];
      lines_d  = '0;
      open_d   = 1'b0;
      halted_d = 1'b0;
    end else if (in_acc_i) begin
      if (in_req_i.is_end) begin
        // End of input: flush the open batch, then the sentinel; re-arm.
        if (!halted_q) begin
          if (end_cnt != '0) begin
            push_o.r0  = mk_res(bb_q, end_cnt, end_cnt != lpb_q, KIND_BATCH);
            push_o.r1  = mk_res(pos_q, '0, 1'b1, KIND_SENTINEL);
            push_o.num = 2'd2;
          end else begin
            push_o.r0  = mk_res(pos_q, '0, 1'b1, KIND_SENTINEL);
            push_o.num = 2'd1;
          end
        end
        pos_d    = start_q;
        bb_d     = start_q;
        lb_d     = start_q;
        lines_d  = '0;
        open_d   = 1'b0;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        if (pos_q == OFFSET_MAX) begin
          push_o.r0  = mk_res(pos_q, '0, 1'b1, KIND_ERROR);
          push_o.num = 2'd1;
          halted_d   = 1'b1;
        end else begin
          pos_d = next_pos;
          if (in_req_i.data_byte == NEWLINE_BYTE) begin
            // Close before this line when it breaks the budget.
            if (over_budget) begin
              push_o.r0  = mk_res(bb_q, lines_q, lines_q != lpb_q, KIND_BATCH);
              push_o.num = 2'd1;
              bb_t       = lb_q;
              lines_t    = '0;
            end
            lines_t = lines_t + COUNT_BITS'(1);
            // Close after this line at the target or the count limit.
            if ((lines_t == lpb_q) || (lines_t == COUNT_MAX)) begin
              res_t = mk_res(bb_t, lines_t, lines_t != lpb_q, KIND_BATCH);
              if (push_o.num == 2'd0) begin
                push_o.r0 = res_t;
              end else begin
                push_o.r1 = res_t;
              end
              push_o.num = push_o.num + 2'd1;
              bb_t       = next_pos;
              lines_t    = '0;
            end
            bb_d    = bb_t;
            lines_d = lines_t;
            lb_d    = next_pos;
            open_d  = 1'b0;
          end else begin
            open_d = 1'b1;
          end
        end
      end
    end

    // Mark the final result of this request.
    if (push_o.num == 2'd1) begin
      push_o.r0.last = 1'b1;
    end else if (push_o.num == 2'd2) begin
      push_o.r1.last = 1'b1;
    end
  end

  // Framing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      bb_q     <= '0;
      lb_q     <= '0;
      lines_q  <= '0;
      open_q   <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      bb_q     <= bb_d;
      lb_q     <= lb_d;
      lines_q  <= lines_d;
      open_q   <= open_d;
      halted_q <= halted_d;
    end
  end

  `NBF_ASSERT(a_halted_silent, (in_acc_i && !in_req_i.is_end && halted_q && !start_wr) |-> (push_o.num == 2'd0), "byte produced a result while halted")
  `NBF_ASSERT(a_error_halts, (push_o.num != 2'd0 && push_o.r0.kind == KIND_ERROR) |=> halted_q, "overflow error did not halt the framer")
  `NBF_ASSERT(a_end_reports, (in_acc_i && in_req_i.is_end && !halted_q && !start_wr) |-> (push_o.num != 2'd0), "end of input gave no sentinel")

endmodule

`default_nettype wire

/* hdl/nbf_out_fifo.sv */
// Small result queue that takes up to two results per cycle and sends one when the receiver is ready.
// Depends on nbf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nbf_out_fifo import nbf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire nbf_push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output nbf_res_t       data_o
);

  nbf_res_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  // Room for the two results a request may produce.
  assign room_o  = (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  // Storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wp_q + FIFO_AW'(1)] <= push_i.r1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + FIFO_AW'(push_i.num);
      rp_q  <= rp_q + FIFO_AW'(pop);
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i.num) - (FIFO_AW+1)'(pop);
    end
  end

  `NBF_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue fill level out of range")
  `NBF_ASSERT(a_no_overflow, (push_i.num != 2'd0) |-> ((cnt_q + (FIFO_AW+1)'(push_i.num)) <= (FIFO_AW+1)'(FIFO_DEPTH)), "result queue overflow")

endmodule

`default_nettype wire

/* sim/newline_batch_framer_tb.sv */
`timescale 1ns / 1ps
// Testbench for newline_batch_framer: sends byte requests and end markers, forecasts every
// batch descriptor from its own framing model and checks each result field by field.
// Depends on nbf_pkg, the nbf_if interfaces and the newline_batch_framer RTL.

module newline_batch_framer_tb;
  import nbf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ZERO_TARGET_LINES = 20;
  localparam logic [63:0] LINE_OVERHEAD = 64'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [7:0] PLAIN_BYTE = 8'h61;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  nbf_in_if  in_ch ();
  nbf_out_if out_ch ();

  newline_batch_framer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // Register copies held by the framing model.
  logic [COUNT_BITS-1:0]  lines_target;
  logic [LIMIT_BITS-1:0]  byte_budget;
  logic [OFFSET_BITS-1:0] base_offset;

  // Framing state of the model.
  logic [OFFSET_BITS-1:0] scan_pos;
  logic [OFFSET_BITS-1:0] batch_base;
  logic [OFFSET_BITS-1:0] line_start;
  logic [COUNT_BITS-1:0]  lines_held;
  logic                   line_open;
  logic                   halted;

  nbf_res_t    pending_descriptors[$];
  nbf_res_t    wanted;
  int unsigned live_items;
  int unsigned mismatches;

  // Stimulus pacing.
  sink_style_e sink_style;
  logic [15:0] stall_pattern;
  logic [3:0]  pattern_idx = '0;
  logic        source_calm;
  int unsigned burst_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver stalls according to the style chosen by the running test.
  always @(posedge clk_i) begin
    case (sink_style)
      SINK_ALWAYS: out_ch.ready <= 1'b1;
      SINK_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= stall_pattern[pattern_idx];
    endcase
    pattern_idx <= pattern_idx + 4'd1;
  end

  function automatic logic [OFFSET_BITS-1:0] random_offset();
    return {16'($urandom), $urandom};
  endfunction

  // Every end of input and every start offset write restart framing from the base.
  function automatic void rearm_model();
    scan_pos    = base_offset;
    batch_base  = base_offset;
    line_start  = base_offset;
    lines_held  = '0;
    line_open   = 1'b0;
    halted      = 1'b0;
  endfunction

  function automatic nbf_res_t descriptor(input logic [OFFSET_BITS-1:0] off,
                                          input logic [COUNT_BITS-1:0] cnt,
                                          input logic part, input kind_e kind);
    nbf_res_t r;
    r.batch_offset = off;
    r.line_count   = cnt;
    r.partial      = part;
    r.kind         = kind;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic nbf_res_t batch_descriptor();
    return descriptor(batch_base, lines_held, lines_held != lines_target, KIND_BATCH);
  endfunction

  // Works out the descriptors one accepted request causes and queues them.
  function automatic void frame_byte(input nbf_in_t req);
    nbf_res_t               found [2];
    int                     n;
    logic [OFFSET_BITS-1:0] nxt;
    logic [63:0]            spend;
    n = 0;
    if (!halted) begin
      live_items++;
    end
    if (req.is_end) begin
      // A trailing unterminated line counts; the open batch is flushed before the sentinel.
      if (!halted) begin
        if (line_open) begin
          lines_held++;
        end
        if (lines_held != '0) begin
          found[n] = batch_descriptor();
          n++;
        end
        found[n] = descriptor(scan_pos, '0, 1'b1, KIND_SENTINEL);
        n++;
      end
      rearm_model();
    end else if (!halted) begin
      if (scan_pos == OFFSET_MAX) begin
        found[n] = descriptor(scan_pos, '0, 1'b1, KIND_ERROR);
        n++;
        halted = 1'b1;
      end else begin
        nxt = scan_pos + 1'b1;
        if (req.data_byte == NEWLINE_BYTE) begin
          // The budget only closes a batch that already holds a line.
          if (byte_budget != '0 && lines_held != '0) begin
            spend = 64'(nxt - batch_base) + (64'(lines_held) + 64'd1) * LINE_OVERHEAD;
            if (spend > 64'(byte_budget)) begin
              found[n] = batch_descriptor();
              n++;
              batch_base = line_start;
              lines_held = '0;
            end
          end
          lines_held++;
          if (lines_held == lines_target || lines_held == COUNT_MAX) begin
            found[n] = batch_descriptor();
            n++;
            batch_base = nxt;
            lines_held = '0;
          end
          line_start = nxt;
          line_open  = 1'b0;
        end else begin
          line_open = 1'b1;
        end
        scan_pos = nxt;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_descriptors.push_back(found[i]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Results are checked before the request of the same edge is framed, so a result can
  // never meet its own expectation in the same step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (pending_descriptors.size() == 0) begin
          report_mismatch("result with nothing expected, offset",
                          64'(out_ch.payload.batch_offset), '0);
        end else begin
          wanted = pending_descriptors.pop_front();
          if (out_ch.payload.batch_offset !== wanted.batch_offset) begin
            report_mismatch("batch_offset", 64'(out_ch.payload.batch_offset),
                            64'(wanted.batch_offset));
          end
          if (out_ch.payload.line_count !== wanted.line_count) begin
            report_mismatch("line_count", 64'(out_ch.payload.line_count),
                            64'(wanted.line_count));
          end
          if (out_ch.payload.partial !== wanted.partial) begin
            report_mismatch("partial", 64'(out_ch.payload.partial), 64'(wanted.partial));
          end
          if (out_ch.payload.kind !== wanted.kind) begin
            report_mismatch("kind", 64'(out_ch.payload.kind), 64'(wanted.kind));
          end
          if (out_ch.payload.last !== wanted.last) begin
            report_mismatch("last", 64'(out_ch.payload.last), 64'(wanted.last));
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready) begin
        frame_byte(in_ch.payload);
      end
    end
  end

  // Sends one request; outside calm stretches it inserts a gap between bursts.
  task automatic send_req(input logic [7:0] b, input logic end_flag);
    nbf_in_t req;
    req.data_byte = b;
    req.is_end    = end_flag;
    if (!source_calm) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left--;
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  // Holds the sender off until every expected result has arrived and the block is quiet.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_descriptors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_LINES_PER_BATCH: lines_target = value[COUNT_BITS-1:0];
      CFG_BYTE_LIMIT: byte_budget = value[LIMIT_BITS-1:0];
      CFG_START_OFFSET: begin
        base_offset = value[OFFSET_BITS-1:0];
        rearm_model();
      end
      default: ;
    endcase
  endtask

  // Reset settings: one line per batch, no budget, stream at offset zero.
  task automatic test_reset_defaults();
    sink_style  = SINK_RANDOM;
    source_calm = 1'b0;
    send_req(PLAIN_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(8'h00, 1'b0);
    // Trailing unterminated line: flushed batch, then the sentinel.
    send_req(8'h5A, 1'b1);
    // End on an empty stream gives the sentinel alone; the byte is ignored.
    send_req(NEWLINE_BYTE, 1'b1);
    send_req(NEWLINE_BYTE, 1'b0);
    drain_results();
  endtask

  // Byte budget closing batches early, the widest budget and target, and the spare index.
  task automatic test_byte_budget();
    write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(3));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(30));
    write_reg(CFG_START_OFFSET, 48'h1000);
    write_reg(CFG_UNUSED_IDX, '1);
    sink_style    = SINK_PATTERN;
    stall_pattern = 16'b1011_0011_1001_0111;
    repeat (4) send_req(PLAIN_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    repeat (9) send_req(8'h7E, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
    write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(COUNT_MAX));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(32'hFFFF_FFFF));
    send_req(PLAIN_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
    // A budget smaller than any two lines splits every batch after its first line.
    write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(2));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(1));
    repeat (3) send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
  endtask

  // Offset overflow: error result, ignored bytes while halted, and the silent re-arm.
  task automatic test_offset_overflow();
    write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(1));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(0));
    write_reg(CFG_START_OFFSET, CFG_DATA_W'(OFFSET_MAX - OFFSET_BITS'(2)));
    sink_style  = SINK_RANDOM;
    source_calm = 1'b0;
    send_req(PLAIN_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b0);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
    write_reg(CFG_START_OFFSET, CFG_DATA_W'(OFFSET_MAX));
    send_req(PLAIN_BYTE, 1'b1);
    send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
  endtask

  // Zero line target: the target is never reached, so batches close only by budget
  // or at end of input, and every one of them is partial.
  task automatic test_zero_target();
    write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(0));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(100));
    write_reg(CFG_START_OFFSET, random_offset());
    sink_style  = SINK_ALWAYS;
    source_calm = 1'b1;
    repeat (ZERO_TARGET_LINES) send_req(NEWLINE_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b0);
    send_req(PLAIN_BYTE, 1'b1);
    drain_results();
  endtask

  // Random phases: mostly whole lines with random content, some noise bytes and ends.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    int unsigned phase;
    logic [7:0]  b;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      pick = $urandom_range(0, 5);
      write_reg(CFG_LINES_PER_BATCH, CFG_DATA_W'(
                pick == 0 ? 0 : (pick == 1 ? COUNT_MAX : $urandom_range(1, 6))));
      pick = $urandom_range(0, 5);
      write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(
                pick < 2 ? 0 : (pick == 2 ? 32'hFFFF_FFFF : $urandom_range(12, 120))));
      pick = $urandom_range(0, 3);
      write_reg(CFG_START_OFFSET, pick == 0 ? 48'd0 :
                (pick == 1 ? OFFSET_MAX - OFFSET_BITS'($urandom_range(0, 60)) :
                 random_offset()));
      if (phase == RANDOM_PHASES / 2) begin
        write_reg(CFG_UNUSED_IDX, random_offset());
      end
      sink_style    = sink_style_e'(phase % 3);
      stall_pattern = 16'($urandom) | 16'h0101;
      source_calm   = (phase % 4 == 3);
      goal = live_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (live_items < goal) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_req(8'($urandom), 1'b1);
        end else if (pick < 3) begin
          send_req(8'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(0, 10)) begin
            b = 8'($urandom_range(0, 254));
            send_req(b >= NEWLINE_BYTE ? b + 8'd1 : b, 1'b0);
          end
          send_req(NEWLINE_BYTE, 1'b0);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_LINES_PER_BATCH;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    sink_style    = SINK_ALWAYS;
    stall_pattern = 16'hFFFF;
    source_calm   = 1'b1;
    burst_left    = 0;
    live_items    = 0;
    mismatches    = 0;
    lines_target  = 16'd1;
    byte_budget   = '0;
    base_offset   = '0;
    rearm_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_byte_budget();
    test_offset_overflow();
    test_zero_target();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/nbf_pkg.sv
hdl/nbf_if.sv
hdl/nbf_core.sv
hdl/nbf_out_fifo.sv
hdl/newline_batch_framer.sv
sim/newline_batch_framer_tb.sv
